[design/sce_pkg.sv]
`default_nettype none
package sce_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int NW          = $clog2(MAX_RESULTS + 1);

  typedef enum logic [4:0] {
    OP_PUSH      = 5'd0,
    OP_ADD       = 5'd1,
    OP_SUB       = 5'd2,
    OP_MUL       = 5'd3,
    OP_DIV       = 5'd4,
    OP_NEG       = 5'd5,
    OP_DROP      = 5'd6,
    OP_DROPN     = 5'd7,
    OP_PRINTNUM  = 5'd8,
    OP_PRINTCHAR = 5'd9,
    OP_CONDSKIP  = 5'd10,
    OP_EQUAL     = 5'd11,
    OP_NOT       = 5'd12,
    OP_PRINTSTR  = 5'd13,
    OP_RESTART   = 5'd14,
    OP_PRESERVE  = 5'd15,
    OP_SQUARE    = 5'd16,
    OP_DUP       = 5'd17,
    OP_PEEKTOP   = 5'd18,
    OP_PEEKIDX   = 5'd19,
    OP_NEWLINE   = 5'd20,
    OP_TAB       = 5'd21,
    OP_HALVE     = 5'd22,
    OP_DOUBLE    = 5'd23,
    OP_SQRT      = 5'd24,
    OP_INC       = 5'd25,
    OP_DEC       = 5'd26
  } op_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NUM  = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW = 3'd1;
  localparam logic [2:0] ERR_DIVZERO  = 3'd2;
  localparam logic [2:0] ERR_RANGE    = 3'd3;
  localparam logic [2:0] ERR_NEGROOT  = 3'd4;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;

  typedef enum logic [1:0] {
    IT_MUL,
    IT_DIV,
    IT_SQRT
  } iter_mode_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_RD_TOP,
    CMD_POP_A,
    CMD_TOP_A,
    CMD_POP_B,
    CMD_RESTORE,
    CMD_EXEC,
    CMD_ITER_TAKE,
    CMD_RD_IDX,
    CMD_MEM_RES,
    CMD_PUSH,
    CMD_EMIT,
    CMD_RD_SCAN,
    CMD_SCAN_CHK,
    CMD_STR_FIN,
    CMD_RD_STR,
    CMD_STR_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic [4:0] op;
    logic       iter_go;
    logic       iter_done;
    logic       peek_ok;
    logic       scan_more;
    logic       scan_nz;
    logic       str_empty;
    logic       str_last;
    logic       out_free;
  } dp_status_t;

  function automatic logic [1:0] op_pops(input logic [4:0] op);
    logic [1:0] n;
    n = 2'd0;
    case (op) inside
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQUAL: n = 2'd2;
      OP_NEG, OP_NOT, OP_SQUARE, OP_HALVE, OP_DOUBLE, OP_SQRT, OP_INC, OP_DEC,
      OP_DROP, OP_DROPN, OP_PRINTCHAR, OP_CONDSKIP, OP_PEEKTOP, OP_PEEKIDX: n = 2'd1;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic op_reads_top(input logic [4:0] op);
    return (op == OP_PRINTNUM) || (op == OP_DUP);
  endfunction

  function automatic logic op_pushes(input logic [4:0] op);
    logic p;
    p = 1'b0;
    case (op) inside
      OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG, OP_EQUAL, OP_NOT, OP_SQUARE,
      OP_DUP, OP_PEEKTOP, OP_PEEKIDX, OP_HALVE, OP_DOUBLE, OP_SQRT, OP_INC,
      OP_DEC: p = 1'b1;
      default: p = 1'b0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

[design/sce_iter.sv]
`default_nettype none
module sce_iter #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire sce_pkg::iter_mode_t    mode,
  input  wire logic [VALUE_WIDTH-1:0] opa,
  input  wire logic [VALUE_WIDTH-1:0] opb,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      result
);
  import sce_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int SW = VW + (VW % 2);
  localparam int AW = VW + 2;
  localparam int CW = $clog2(VW + 1);

  logic             busy_r;
  logic             done_r;
  iter_mode_t       mode_r;
  logic [CW-1:0]    cnt_r;
  logic [SW-1:0]    x_r;
  logic [VW-1:0]    y_r;
  logic [AW-1:0]    acc_r;
  logic [VW-1:0]    q_r;
  logic             neg_r;

  logic [AW-1:0]    div_sh;
  logic             div_ge;
  logic [AW-1:0]    sq_sh;
  logic [AW-1:0]    sq_trial;
  logic             sq_ge;
  logic [VW-1:0]    mag_a;
  logic [VW-1:0]    mag_b;

  // restoring divide: one quotient bit per cycle; root: one bit pair per cycle
  assign div_sh   = {acc_r[AW-2:0], x_r[VW-1]};
  assign div_ge   = div_sh >= {2'b00, y_r};
  assign sq_sh    = {acc_r[AW-3:0], x_r[SW-1:SW-2]};
  assign sq_trial = {q_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign mag_a    = opa[VW-1] ? -opa : opa;
  assign mag_b    = opb[VW-1] ? -opb : opb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        mode_r <= mode;
        acc_r  <= '0;
        q_r    <= '0;
        case (mode)
          IT_MUL: begin
            x_r   <= SW'(opa);
            y_r   <= opb;
            cnt_r <= CW'(VW);
          end
          IT_DIV: begin
            x_r   <= SW'(mag_b);
            y_r   <= mag_a;
            neg_r <= opa[VW-1] ^ opb[VW-1];
            cnt_r <= CW'(VW);
          end
          default: begin
            x_r   <= SW'(opa);
            cnt_r <= CW'(SW / 2);
          end
        endcase
      end else if (busy_r) begin
        case (mode_r)
          IT_MUL: begin
            if (y_r[0]) acc_r <= AW'(acc_r[VW-1:0] + x_r[VW-1:0]);
            x_r <= x_r << 1;
            y_r <= y_r >> 1;
          end
          IT_DIV: begin
            acc_r <= div_ge ? (div_sh - {2'b00, y_r}) : div_sh;
            q_r   <= {q_r[VW-2:0], div_ge};
            x_r   <= x_r << 1;
          end
          default: begin
            acc_r <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
            q_r   <= {q_r[VW-2:0], sq_ge};
            x_r   <= x_r << 2;
          end
        endcase
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (mode_r)
      IT_MUL:  result = acc_r[VW-1:0];
      IT_DIV:  result = neg_r ? -q_r : q_r;
      default: result = q_r;
    endcase
  end

  assign done = done_r;

endmodule
`default_nettype wire

[design/sce_datapath.sv]
`default_nettype none
module sce_datapath #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sce_pkg::dp_cmd_t   cmd,
  input  wire logic [4:0]         in_op,
  input  wire logic signed [31:0] in_push_value,
  input  wire logic               out_ready,
  output sce_pkg::dp_status_t     status,
  output logic                    out_valid,
  output logic [1:0]              out_kind,
  output logic signed [31:0]      out_value,
  output logic                    out_last,
  output logic                    out_skip_next,
  output logic                    out_restart_flag,
  output logic [2:0]              out_error_code,
  output logic [6:0]              out_stack_depth
);
  import sce_pkg::*;

  localparam int VW   = VALUE_WIDTH;
  localparam int ADW  = $clog2(STACK_DEPTH);
  localparam int CNTW = $clog2(STACK_DEPTH + 1);
  localparam int MW   = ((VW > CNTW) ? VW : CNTW) + 1;

  logic [VW-1:0]   mem [STACK_DEPTH];
  logic [VW-1:0]   rdata_r;

  logic [CNTW-1:0] count_r;
  logic [CNTW-1:0] saved_r;
  logic [1:0]      keep_cnt_r;
  logic            keep_r;
  logic [4:0]      op_r;
  logic [VW-1:0]   pv_r;
  logic [VW-1:0]   a_r;
  logic [VW-1:0]   b_r;
  logic [VW-1:0]   res_r;
  logic [2:0]      err_r;
  logic            skip_r;
  logic            restart_r;
  logic [NW-1:0]   n_r;
  logic [NW-1:0]   e_r;

  logic            out_valid_r;
  logic [1:0]      out_kind_r;
  logic [31:0]     out_value_r;
  logic            out_last_r;
  logic            out_skip_r;
  logic            out_restart_r;
  logic [2:0]      out_err_r;
  logic [6:0]      out_depth_r;

  logic [1:0]      kc_dec;
  logic            full;
  logic            peek_ok;
  logic [CNTW-1:0] peek_idx;
  logic [CNTW-1:0] rd_ptr;
  logic            rd_en;
  logic            iter_go;
  logic            iter_done;
  logic [VW-1:0]   iter_res;
  iter_mode_t      iter_mode;
  logic [VW-1:0]   iter_b;
  logic signed [VW-1:0] half_s;
  logic signed [63:0]   a_wide;
  logic            str_term;
  logic            out_free;

  assign kc_dec   = (keep_cnt_r == 2'd0) ? 2'd0 : keep_cnt_r - 2'd1;
  assign full     = (count_r == CNTW'(STACK_DEPTH));
  assign peek_ok  = !a_r[VW-1] && (MW'(a_r) < MW'(count_r));
  assign peek_idx = (op_r == OP_PEEKTOP) ? (count_r - 1'b1 - CNTW'(a_r)) : CNTW'(a_r);
  assign half_s   = $signed(a_r + {{(VW-1){1'b0}}, a_r[VW-1]});
  assign a_wide   = 64'($signed(a_r));
  assign str_term = (n_r < NW'(MAX_RESULTS)) && (32'(count_r) > 32'(n_r));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (op_r) inside
      OP_MUL, OP_SQUARE: iter_mode = IT_MUL;
      OP_DIV:            iter_mode = IT_DIV;
      default:           iter_mode = IT_SQRT;
    endcase
    case (op_r) inside
      OP_MUL, OP_SQUARE: iter_go = 1'b1;
      OP_DIV:            iter_go = (a_r != '0);
      OP_SQRT:           iter_go = !a_r[VW-1];
      default:           iter_go = 1'b0;
    endcase
    iter_b = (op_r == OP_SQUARE) ? a_r : b_r;
  end

  sce_iter #(
    .VALUE_WIDTH(VW)
  ) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  ((cmd == CMD_EXEC) && iter_go),
    .mode   (iter_mode),
    .opa    (a_r),
    .opb    (iter_b),
    .done   (iter_done),
    .result (iter_res)
  );

  always_comb begin
    rd_en  = 1'b1;
    rd_ptr = count_r - 1'b1;
    case (cmd)
      CMD_RD_TOP:  rd_ptr = count_r - 1'b1;
      CMD_RD_IDX:  rd_ptr = peek_idx;
      CMD_RD_SCAN: rd_ptr = count_r - 1'b1 - CNTW'(n_r);
      CMD_RD_STR:  rd_ptr = saved_r - 1'b1 - CNTW'(e_r);
      default:     rd_en  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if ((cmd == CMD_PUSH) && !full) mem[count_r[ADW-1:0]] <= res_r;
    if (rd_en) rdata_r <= mem[rd_ptr[ADW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      keep_cnt_r  <= 2'd0;
      keep_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && (cmd != CMD_EMIT) && (cmd != CMD_STR_EMIT)) out_valid_r <= 1'b0;
      case (cmd)
        CMD_LOAD: begin
          op_r       <= in_op;
          pv_r       <= VW'(in_push_value);
          saved_r    <= count_r;
          keep_cnt_r <= kc_dec;
          keep_r     <= (kc_dec != 2'd0);
          err_r      <= ERR_OK;
          skip_r     <= 1'b0;
          restart_r  <= 1'b0;
          n_r        <= '0;
          e_r        <= '0;
        end
        CMD_POP_A: begin
          a_r <= (count_r != '0) ? rdata_r : '0;
          if (count_r != '0) count_r <= count_r - 1'b1;
        end
        CMD_TOP_A: a_r <= (count_r != '0) ? rdata_r : '0;
        CMD_POP_B: begin
          b_r <= (count_r != '0) ? rdata_r : '0;
          if (count_r != '0) count_r <= count_r - 1'b1;
        end
        CMD_RESTORE: if (keep_r) count_r <= saved_r;
        CMD_EXEC: begin
          case (op_r)
            OP_PUSH:     res_r <= pv_r;
            OP_ADD:      res_r <= b_r + a_r;
            OP_SUB:      res_r <= b_r - a_r;
            OP_DIV: begin
              res_r <= '0;
              if (a_r == '0) err_r <= ERR_DIVZERO;
            end
            OP_NEG:      res_r <= '0 - a_r;
            OP_EQUAL:    res_r <= VW'(a_r == b_r);
            OP_NOT:      res_r <= VW'(a_r == '0);
            OP_HALVE:    res_r <= half_s >>> 1;
            OP_DOUBLE:   res_r <= a_r << 1;
            OP_SQRT: begin
              res_r <= '0;
              if (a_r[VW-1]) err_r <= ERR_NEGROOT;
            end
            OP_INC:      res_r <= a_r + 1'b1;
            OP_DEC:      res_r <= a_r - 1'b1;
            OP_DUP:      res_r <= a_r;
            OP_CONDSKIP: skip_r <= (a_r != '0);
            OP_RESTART:  restart_r <= 1'b1;
            OP_PRESERVE: keep_cnt_r <= 2'd2;
            OP_DROPN: begin
              if (!a_r[VW-1] && (a_r != '0)) begin
                count_r <= (MW'(a_r) >= MW'(count_r)) ? '0 : count_r - CNTW'(a_r);
              end
            end
            OP_PEEKTOP, OP_PEEKIDX: begin
              res_r <= '0;
              if (!peek_ok) err_r <= ERR_RANGE;
            end
            default: res_r <= '0;
          endcase
        end
        CMD_ITER_TAKE: res_r <= iter_res;
        CMD_MEM_RES:   res_r <= rdata_r;
        CMD_PUSH: begin
          if (full) begin
            if (err_r == ERR_OK) err_r <= ERR_OVERFLOW;
          end else begin
            count_r <= count_r + 1'b1;
          end
        end
        CMD_SCAN_CHK: if (rdata_r != '0) n_r <= n_r + 1'b1;
        CMD_STR_FIN: begin
          if (!keep_r) count_r <= count_r - CNTW'(n_r) - CNTW'(str_term);
        end
        CMD_EMIT: begin
          out_valid_r   <= 1'b1;
          out_last_r    <= 1'b1;
          out_skip_r    <= skip_r;
          out_restart_r <= restart_r;
          out_err_r     <= err_r;
          out_depth_r   <= 7'(count_r);
          case (op_r)
            OP_PRINTNUM: begin
              out_kind_r  <= KIND_NUM;
              out_value_r <= a_wide[31:0];
            end
            OP_PRINTCHAR: begin
              out_kind_r  <= KIND_CHAR;
              out_value_r <= {24'd0, a_r[7:0]};
            end
            OP_NEWLINE: begin
              out_kind_r  <= KIND_CHAR;
              out_value_r <= {24'd0, CH_NEWLINE};
            end
            OP_TAB: begin
              out_kind_r  <= KIND_CHAR;
              out_value_r <= {24'd0, CH_TAB};
            end
            default: begin
              out_kind_r  <= KIND_NONE;
              out_value_r <= '0;
            end
          endcase
        end
        CMD_STR_EMIT: begin
          out_valid_r   <= 1'b1;
          out_kind_r    <= KIND_CHAR;
          out_value_r   <= {24'd0, rdata_r[7:0]};
          out_last_r    <= (e_r == n_r - 1'b1);
          out_skip_r    <= skip_r;
          out_restart_r <= restart_r;
          out_err_r     <= err_r;
          out_depth_r   <= 7'(count_r);
          e_r           <= e_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.op        = op_r;
    status.iter_go   = iter_go;
    status.iter_done = iter_done;
    status.peek_ok   = peek_ok;
    status.scan_more = (32'(n_r) < 32'(count_r)) && (n_r < NW'(MAX_RESULTS));
    status.scan_nz   = (rdata_r != '0);
    status.str_empty = (n_r == '0);
    status.str_last  = (e_r == n_r - 1'b1);
    status.out_free  = out_free;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_value        = out_value_r;
  assign out_last         = out_last_r;
  assign out_skip_next    = out_skip_r;
  assign out_restart_flag = out_restart_r;
  assign out_error_code   = out_err_r;
  assign out_stack_depth  = out_depth_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_PUSH) && !full |=> count_r == $past(count_r) + 1'b1)
    else $error("push with room did not grow the stack");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_EMIT) || (cmd == CMD_STR_EMIT) |-> out_free)
    else $error("result register overwritten before transfer");

endmodule
`default_nettype wire

[design/sce_ctrl.sv]
`default_nettype none
module sce_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sce_pkg::dp_status_t status,
  output sce_pkg::dp_cmd_t         cmd
);
  import sce_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DEC,
    S_POPA,
    S_RDB,
    S_POPB,
    S_RESTORE,
    S_EXEC,
    S_WAIT,
    S_RDIDX,
    S_TAKEIDX,
    S_PUSH,
    S_EMIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_STR_FIN,
    S_STR_RD,
    S_STR_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (status.op == OP_PRINTSTR) begin
          state_nxt = S_SCAN_RD;
        end else if ((op_pops(status.op) != 2'd0) || op_reads_top(status.op)) begin
          cmd       = CMD_RD_TOP;
          state_nxt = S_POPA;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_POPA: begin
        if (op_reads_top(status.op)) begin
          cmd       = CMD_TOP_A;
          state_nxt = S_EXEC;
        end else begin
          cmd       = CMD_POP_A;
          state_nxt = (op_pops(status.op) == 2'd2) ? S_RDB : S_RESTORE;
        end
      end
      S_RDB: begin
        cmd       = CMD_RD_TOP;
        state_nxt = S_POPB;
      end
      S_POPB: begin
        cmd       = CMD_POP_B;
        state_nxt = S_RESTORE;
      end
      S_RESTORE: begin
        cmd       = CMD_RESTORE;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd = CMD_EXEC;
        if (status.iter_go) begin
          state_nxt = S_WAIT;
        end else if (((status.op == OP_PEEKTOP) || (status.op == OP_PEEKIDX))
                     && status.peek_ok) begin
          state_nxt = S_RDIDX;
        end else if (op_pushes(status.op)) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_WAIT: begin
        if (status.iter_done) begin
          cmd       = CMD_ITER_TAKE;
          state_nxt = S_PUSH;
        end
      end
      S_RDIDX: begin
        cmd       = CMD_RD_IDX;
        state_nxt = S_TAKEIDX;
      end
      S_TAKEIDX: begin
        cmd       = CMD_MEM_RES;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd       = CMD_PUSH;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd       = CMD_EMIT;
          state_nxt = S_IDLE;
        end
      end
      // string print: count the chars first so every transfer carries the final depth
      S_SCAN_RD: begin
        if (status.scan_more) begin
          cmd       = CMD_RD_SCAN;
          state_nxt = S_SCAN_CHK;
        end else begin
          state_nxt = S_STR_FIN;
        end
      end
      S_SCAN_CHK: begin
        cmd       = CMD_SCAN_CHK;
        state_nxt = status.scan_nz ? S_SCAN_RD : S_STR_FIN;
      end
      S_STR_FIN: begin
        cmd       = CMD_STR_FIN;
        state_nxt = status.str_empty ? S_EMIT : S_STR_RD;
      end
      S_STR_RD: begin
        cmd       = CMD_RD_STR;
        state_nxt = S_STR_OUT;
      end
      S_STR_OUT: begin
        if (status.out_free) begin
          cmd       = CMD_STR_EMIT;
          state_nxt = status.str_last ? S_IDLE : S_STR_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[design/stack_command_engine_core.sv]
`default_nettype none
// Stack command engine: runs one stack-machine command per input transfer on an
// operand stack of STACK_DEPTH signed VALUE_WIDTH-bit entries and returns one or
// more result transfers per command (out_last marks the final one). Commands run
// one at a time; in_ready is high only between commands, while a finished result
// may still sit in the output register. Push, drop, dup and simple arithmetic
// need no iterative unit; multiply, square, divide and square root go through
// a shared iterative unit that settles one bit (one bit pair for root) per
// cycle. A string print scans the stack first and then reads it again, each
// emitted char waiting until the output register is free. The stack sits in
// a single-port style memory with a registered read, one access per cycle, so
// every pop is preceded by a read of the top entry. No clearing pass is needed.
module stack_command_engine_core #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [4:0]         in_op,
  input  wire logic signed [31:0] in_push_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_kind,
  output logic signed [31:0]      out_value,
  output logic                    out_last,
  output logic                    out_skip_next,
  output logic                    out_restart_flag,
  output logic [2:0]              out_error_code,
  output logic [6:0]              out_stack_depth
);
  import sce_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sce_datapath #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_op            (in_op),
    .in_push_value    (in_push_value),
    .out_ready        (out_ready),
    .status           (status),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_value        (out_value),
    .out_last         (out_last),
    .out_skip_next    (out_skip_next),
    .out_restart_flag (out_restart_flag),
    .out_error_code   (out_error_code),
    .out_stack_depth  (out_stack_depth)
  );

endmodule
`default_nettype wire
